// File: rtl/core/onb_pkg.sv
// Shared types, constants and sizes for the Oren-Nayar reflectance evaluator.
`default_nettype none
package onb_pkg;

  // Number of cells in the square-root / A-B division row and in the tangent division row.
  localparam int ROOT_STEPS = 16;
  localparam int TERM_STEPS = 30;

  // Pipeline depth up to the output buffer.
  localparam int PIPE_DEPTH = 3 + ROOT_STEPS + 3 + TERM_STEPS + 3;

  // Division cell widths: divisor/remainder and the numerator/quotient shift register.
  localparam int DIV_DW = 36;
  localparam int DIV_NW = 30;
  // Quotient bits produced for A and B.
  localparam int QAB_BITS = 16;

  // Square-root cell widths: radicand, root and partial remainder.
  localparam int SQ_RW = 32;
  localparam int SQ_OW = 16;
  localparam int SQ_MW = 18;

  typedef logic signed [15:0] q14_t;
  typedef logic [15:0]        q15_t;
  typedef logic signed [23:0] refl_t;

  typedef struct packed {
    logic [DIV_DW-1:0] rem;
    logic [DIV_NW-1:0] nq;
    logic [DIV_DW-1:0] den;
  } div_st_t;

  typedef struct packed {
    logic [SQ_MW-1:0] rem;
    logic [SQ_OW-1:0] root;
    logic [SQ_RW-1:0] rad;
  } sqrt_st_t;

  // Scaled constants: 0.57 and 0.09 in Q2.30, 1/pi in Q0.32.
  localparam logic [32:0] K057_Q30   = 33'd612032840;
  localparam logic [32:0] K009_Q30   = 33'd96636764;
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic [31:0] ONE_Q28    = 32'd268435456;
  localparam refl_t       OUT_MAX    = 24'sh7FFFFF;
  localparam refl_t       OUT_MIN    = 24'sh800000;

endpackage
`default_nettype wire

// File: rtl/core/onb_req_if.sv
// Request channel carrying the directions, normal, roughness and albedo sample.
`default_nettype none
interface onb_req_if;
  import onb_pkg::*;

  logic valid;
  logic ready;
  q14_t dir_in_x;
  q14_t dir_in_y;
  q14_t dir_in_z;
  q14_t dir_out_x;
  q14_t dir_out_y;
  q14_t dir_out_z;
  q14_t norm_x;
  q14_t norm_y;
  q14_t norm_z;
  q15_t rough;
  q15_t albedo_sample;

  modport source (
    output valid, dir_in_x, dir_in_y, dir_in_z, dir_out_x, dir_out_y, dir_out_z,
    output norm_x, norm_y, norm_z, rough, albedo_sample,
    input  ready
  );

  modport sink (
    input  valid, dir_in_x, dir_in_y, dir_in_z, dir_out_x, dir_out_y, dir_out_z,
    input  norm_x, norm_y, norm_z, rough, albedo_sample,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/onb_rsp_if.sv
// Result channel carrying the reflectance value.
`default_nettype none
interface onb_rsp_if;
  import onb_pkg::*;

  logic  valid;
  logic  ready;
  refl_t reflectance;

  modport source (output valid, reflectance, input ready);
  modport sink (input valid, reflectance, output ready);
endinterface
`default_nettype wire

// File: rtl/core/onb_div_cell.sv
// One restoring division step: one quotient bit per cell, registered.
`default_nettype none
module onb_div_cell (
  input  logic             clk,
  input  logic             en,
  input  onb_pkg::div_st_t d,
  output onb_pkg::div_st_t q
);
  import onb_pkg::*;

  logic [DIV_DW:0] trial;
  logic [DIV_DW:0] diff;
  logic            fits;

  // Bring down the next numerator bit and try the divisor.
  assign trial = {d.rem, d.nq[DIV_NW-1]};
  assign diff  = trial - {1'b0, d.den};
  assign fits  = (trial >= {1'b0, d.den});

  // The quotient bit enters at the bottom of the numerator shift register.
  always_ff @(posedge clk) begin
    if (en) begin
      q.rem <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      q.nq  <= {d.nq[DIV_NW-2:0], fits};
      q.den <= d.den;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/onb_sqrt_cell.sv
// One digit-by-digit integer square-root step: one root bit per cell, registered.
`default_nettype none
module onb_sqrt_cell (
  input  logic              clk,
  input  logic              en,
  input  onb_pkg::sqrt_st_t d,
  output onb_pkg::sqrt_st_t q
);
  import onb_pkg::*;

  logic [SQ_MW+1:0] rem_sh;
  logic [SQ_MW+1:0] trial;
  logic [SQ_MW+1:0] diff;
  logic             fits;

  // Shift in the next two radicand bits and compare with 4*root+1.
  assign rem_sh = {d.rem, d.rad[SQ_RW-1 -: 2]};
  assign trial  = (SQ_MW+2)'({d.root, 2'b01});
  assign diff   = rem_sh - trial;
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      q.rem  <= fits ? diff[SQ_MW-1:0] : rem_sh[SQ_MW-1:0];
      q.root <= {d.root[SQ_OW-2:0], fits};
      q.rad  <= {d.rad[SQ_RW-3:0], 2'b00};
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/oren_nayar_brdf_eval.sv
// Top level of the Oren-Nayar reflectance evaluator: pipeline, cell rows and output buffer.
//
// Takes one request per clock while ready is high and returns one reflectance value per
// request, in order. Results are registered at the result port. The pipeline holds
// three front stages (dot products, roughness terms, angle cosines), a row of 16 cells
// that forms sin(alpha), sin(beta), A and B one bit per cell, three product stages, a row
// of 30 division cells for the tangent term, and three stages of scaling and saturation.
// A two-entry output buffer sits at the end; ready drops only when both entries hold
// results that the consumer has not taken, and the whole pipeline holds until one leaves.
`default_nettype none
module oren_nayar_brdf_eval (
  input  logic          clk,
  input  logic          rst,
  onb_req_if.sink       req,
  onb_rsp_if.source     rsp
);
  import onb_pkg::*;

  // Round a Q2.28 dot product to Q.14 and clamp it.
  function automatic q14_t cos_q14(input logic signed [31:0] a, input logic signed [31:0] b,
                                   input logic signed [31:0] c, input logic lo_zero);
    logic signed [33:0] s;
    logic signed [33:0] r;
    q14_t               res;
    s = 34'(a) + 34'(b) + 34'(c);
    r = (s + 34'sd8192) >>> 14;
    priority if (r > 34'sd16384) begin
      res = 16'sd16384;
    end else if (lo_zero && r < 34'sd0) begin
      res = 16'sd0;
    end else if (r < -34'sd16384) begin
      res = -16'sd16384;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;

  // Stage 1 products.
  logic signed [31:0] pin  [3];
  logic signed [31:0] pout [3];
  logic signed [31:0] pdd  [3];
  logic [31:0]        s1_s2;
  logic [15:0]        s1_alb;

  // Stage 2 cosines and divider setup.
  q14_t        s2_c1;
  q14_t        s2_c2;
  logic [14:0] s2_cdd;
  logic [15:0] s2_alb;
  div_st_t     s2_da;
  div_st_t     s2_db;
  logic [32:0] den_a;
  logic [47:0] num_a;
  logic [32:0] sk_b;
  logic [35:0] den_b;
  logic [50:0] num_b;

  // Stage 3 angle setup.
  q14_t               cmin;
  q14_t               cmax;
  q14_t               cabs;
  logic signed [31:0] sq_min;
  logic signed [31:0] sq_max;

  // First cell row: square roots and A/B division.
  div_st_t     da   [ROOT_STEPS+1];
  div_st_t     db   [ROOT_STEPS+1];
  sqrt_st_t    sqa  [ROOT_STEPS+1];
  sqrt_st_t    sqb  [ROOT_STEPS+1];
  logic [14:0] r1_cdd  [ROOT_STEPS+1];
  logic [14:0] r1_cm   [ROOT_STEPS+1];
  logic        r1_cneg [ROOT_STEPS+1];
  logic [15:0] r1_alb  [ROOT_STEPS+1];

  // Product stages.
  logic [16:0] p1_aq;
  logic [29:0] p1_pb;
  logic [29:0] p1_ps;
  logic [14:0] p1_cm;
  logic        p1_cneg;
  logic [15:0] p1_alb;
  logic [57:0] p2_p;
  logic [16:0] p2_aq;
  logic [14:0] p2_cm;
  logic        p2_cneg;
  logic [15:0] p2_alb;
  logic [14:0] cmx;
  logic [57:0] nsum;

  // Second cell row: tangent division.
  div_st_t     td      [TERM_STEPS+1];
  logic [16:0] r2_aq   [TERM_STEPS+1];
  logic        r2_cneg [TERM_STEPS+1];
  logic [15:0] r2_alb  [TERM_STEPS+1];

  // Final stages.
  logic signed [31:0] aqx;
  logic signed [31:0] termx;
  logic signed [31:0] sv;
  logic signed [31:0] sv_abs;
  logic               f1_neg;
  logic [30:0]        f1_abs;
  logic [15:0]        f1_alb;
  logic               f2_neg;
  logic [46:0]        f2_m;
  logic               f3_neg;
  logic [54:0]        f3_plo;
  logic [53:0]        f3_phi;
  logic [55:0]        low_sum;
  logic [54:0]        mag_sum;
  logic [31:0]        mag;
  refl_t              res;

  // Output buffer.
  logic  obuf_v;
  refl_t obuf_d;
  logic  skid_v;
  refl_t skid_d;

  // The pipeline moves whenever the skid entry is free.
  assign en        = ~skid_v;
  assign req.ready = en;

  // Valid bits follow the requests through every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], req.valid};
    end
  end

  // Stage 1: the nine dot-product terms and sigma squared.
  always_ff @(posedge clk) begin
    if (en) begin
      pin[0]  <= req.dir_in_x * req.norm_x;
      pin[1]  <= req.dir_in_y * req.norm_y;
      pin[2]  <= req.dir_in_z * req.norm_z;
      pout[0] <= req.dir_out_x * req.norm_x;
      pout[1] <= req.dir_out_y * req.norm_y;
      pout[2] <= req.dir_out_z * req.norm_z;
      pdd[0]  <= req.dir_in_x * req.dir_out_x;
      pdd[1]  <= req.dir_in_y * req.dir_out_y;
      pdd[2]  <= req.dir_in_z * req.dir_out_z;
      s1_s2   <= req.rough * req.rough;
      s1_alb  <= req.albedo_sample;
    end
  end

  // Stage 2 setup: rounded numerators and denominators for A and B.
  always_comb begin
    den_a = 33'(s1_s2) + K057_Q30;
    num_a = (48'(s1_s2) << 15) + 48'(den_a >> 1);
    sk_b  = 33'(s1_s2) + K009_Q30;
    den_b = (36'(sk_b) << 3) + (36'(sk_b) << 1);
    num_b = (51'(s1_s2) << 18) + (51'(s1_s2) << 15) + 51'(den_b >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_c1     <= cos_q14(pin[0], pin[1], pin[2], 1'b0);
      s2_c2     <= cos_q14(pout[0], pout[1], pout[2], 1'b0);
      s2_cdd    <= 15'(cos_q14(pdd[0], pdd[1], pdd[2], 1'b1));
      s2_alb    <= s1_alb;
      s2_da.rem <= DIV_DW'(num_a[47:QAB_BITS]);
      s2_da.nq  <= {num_a[QAB_BITS-1:0], (DIV_NW-QAB_BITS)'(0)};
      s2_da.den <= DIV_DW'(den_a);
      s2_db.rem <= DIV_DW'(num_b[50:QAB_BITS]);
      s2_db.nq  <= {num_b[QAB_BITS-1:0], (DIV_NW-QAB_BITS)'(0)};
      s2_db.den <= den_b;
    end
  end

  // Stage 3: order the cosines and form the square-root radicands.
  always_comb begin
    cmin   = (s2_c1 < s2_c2) ? s2_c1 : s2_c2;
    cmax   = (s2_c1 < s2_c2) ? s2_c2 : s2_c1;
    cabs   = cmax[15] ? -cmax : cmax;
    sq_min = cmin * cmin;
    sq_max = cmax * cmax;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqa[0].rem  <= '0;
      sqa[0].root <= '0;
      sqa[0].rad  <= ONE_Q28 - 32'(sq_min);
      sqb[0].rem  <= '0;
      sqb[0].root <= '0;
      sqb[0].rad  <= ONE_Q28 - 32'(sq_max);
      da[0]       <= s2_da;
      db[0]       <= s2_db;
      r1_cdd[0]   <= s2_cdd;
      r1_cm[0]    <= cabs[14:0];
      r1_cneg[0]  <= cmax[15];
      r1_alb[0]   <= s2_alb;
    end
  end

  // First row: each cell yields one bit of both sines and of both A and B quotients.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_row1
    onb_div_cell  u_div_a  (.clk(clk), .en(en), .d(da[k]),  .q(da[k+1]));
    onb_div_cell  u_div_b  (.clk(clk), .en(en), .d(db[k]),  .q(db[k+1]));
    onb_sqrt_cell u_sqrt_a (.clk(clk), .en(en), .d(sqa[k]), .q(sqa[k+1]));
    onb_sqrt_cell u_sqrt_b (.clk(clk), .en(en), .d(sqb[k]), .q(sqb[k+1]));

    always_ff @(posedge clk) begin
      if (en) begin
        r1_cdd[k+1]  <= r1_cdd[k];
        r1_cm[k+1]   <= r1_cm[k];
        r1_cneg[k+1] <= r1_cneg[k];
        r1_alb[k+1]  <= r1_alb[k];
      end
    end
  end

  // Product stages: B*cdd and sin(alpha)*sin(beta), then their product.
  always_ff @(posedge clk) begin
    if (en) begin
      p1_aq   <= 17'd65536 - 17'(da[ROOT_STEPS].nq[QAB_BITS-1:0]);
      p1_pb   <= 30'(db[ROOT_STEPS].nq[14:0]) * 30'(r1_cdd[ROOT_STEPS]);
      p1_ps   <= 30'(sqa[ROOT_STEPS].root[14:0]) * 30'(sqb[ROOT_STEPS].root[14:0]);
      p1_cm   <= r1_cm[ROOT_STEPS];
      p1_cneg <= r1_cneg[ROOT_STEPS];
      p1_alb  <= r1_alb[ROOT_STEPS];
      p2_p    <= 58'(p1_pb) * 58'(p1_ps);
      p2_aq   <= p1_aq;
      p2_cm   <= p1_cm;
      p2_cneg <= p1_cneg;
      p2_alb  <= p1_alb;
    end
  end

  // Fold the 2^28 scale and the rounding half into the tangent numerator.
  always_comb begin
    cmx  = (p2_cm == 15'd0) ? 15'd1 : p2_cm;
    nsum = p2_p + (58'(cmx) << 27);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      td[0].rem  <= '0;
      td[0].nq   <= nsum[57:28];
      td[0].den  <= DIV_DW'(cmx);
      r2_aq[0]   <= p2_aq;
      r2_cneg[0] <= p2_cneg;
      r2_alb[0]  <= p2_alb;
    end
  end

  // Second row: divide by |cos(beta)|, one quotient bit per cell.
  for (genvar k = 0; k < TERM_STEPS; k++) begin : g_row2
    onb_div_cell u_div_t (.clk(clk), .en(en), .d(td[k]), .q(td[k+1]));

    always_ff @(posedge clk) begin
      if (en) begin
        r2_aq[k+1]   <= r2_aq[k];
        r2_cneg[k+1] <= r2_cneg[k];
        r2_alb[k+1]  <= r2_alb[k];
      end
    end
  end

  // Sum A and the signed tangent term.
  always_comb begin
    aqx    = {15'd0, r2_aq[TERM_STEPS]};
    termx  = {2'd0, td[TERM_STEPS].nq};
    sv     = r2_cneg[TERM_STEPS] ? (aqx - termx) : (aqx + termx);
    sv_abs = sv[31] ? -sv : sv;
  end

  // Scale by albedo, then by 1/pi in two partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      f1_neg <= sv[31];
      f1_abs <= sv_abs[30:0];
      f1_alb <= r2_alb[TERM_STEPS];
      f2_neg <= f1_neg;
      f2_m   <= 47'(f1_alb) * 47'(f1_abs);
      f3_neg <= f2_neg;
      f3_plo <= 55'(f2_m[23:0]) * 55'(INV_PI_Q32);
      f3_phi <= 54'(f2_m[46:24]) * 54'(INV_PI_Q32);
    end
  end

  // Combine the partial products, round, apply the sign and saturate.
  always_comb begin
    low_sum = 56'(f3_plo) + (56'd1 << 46);
    mag_sum = 55'(f3_phi) + 55'(low_sum[55:24]);
    mag     = mag_sum[54:23];
    if (f3_neg) begin
      res = (mag > 32'd8388608) ? OUT_MIN : (24'sd0 - refl_t'(mag[23:0]));
    end else begin
      res = (mag > 32'd8388607) ? OUT_MAX : refl_t'(mag[23:0]);
    end
  end

  // Two-entry output buffer; the skid entry catches a result while the head waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (obuf_v && !rsp.ready) begin
        if (vld[PIPE_DEPTH-1] && en) begin
          skid_v <= 1'b1;
          skid_d <= res;
        end
      end else if (skid_v) begin
        obuf_v <= 1'b1;
        obuf_d <= skid_d;
        skid_v <= 1'b0;
      end else begin
        obuf_v <= vld[PIPE_DEPTH-1] && en;
        obuf_d <= res;
      end
    end
  end

  assign rsp.valid       = obuf_v;
  assign rsp.reflectance = obuf_d;

  // The skid entry only fills behind a waiting head entry.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst) skid_v |-> obuf_v)
    else $error("skid entry holds a result while the head entry is empty");

  // A full buffer with a stalled consumer keeps the request side closed.
  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_v && !rsp.ready) |=> !req.ready)
    else $error("request accepted while both output entries are held");

  // The A divider starts with a remainder below its divisor.
  a_div_a_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (da[0].rem < da[0].den))
    else $error("A quotient does not fit the divider row");

  // Sines never exceed one at the end of the root row.
  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    vld[2+ROOT_STEPS] |-> (sqa[ROOT_STEPS].root <= 16'd16384 &&
                           sqb[ROOT_STEPS].root <= 16'd16384))
    else $error("sine above one");

endmodule
`default_nettype wire

// File: test/onb_checker.sv
// Checker that predicts the reflectance of each request and compares it with each result.
module onb_checker (
  input  logic       clk,
  input  logic       rst,
  onb_req_if.sink    req,
  onb_rsp_if.sink    rsp,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import onb_pkg::*;

  localparam longint ONE_Q14 = 16384;

  refl_t want_refl_q[$];

  // Round half up of v / 2^14.
  function automatic longint round_q14(longint v);
    longint w;
    w = v + 8192;
    if (w >= 0) return w >>> 14;
    return -(((-w) + 16383) >>> 14);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Floor integer square root.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic refl_t brdf_value(
      longint ix, longint iy, longint iz, longint ox, longint oy, longint oz,
      longint nx, longint ny, longint nz, longint unsigned sig, longint unsigned alb);
    longint unsigned s2, den, a16, den2, b16, sa, sb, p, cm, dv, m, mh, ml, lo, mag;
    longint c1, c2, cdd, cmin, cmax, term, s;
    bit neg;
    s2 = sig * sig;
    den = s2 + K057_Q30;
    a16 = 65536 - ((32768 * s2 + den / 2) / den);
    den2 = 10 * (s2 + K009_Q30);
    b16 = (294912 * s2 + den2 / 2) / den2;
    c1 = clamp(round_q14(ix * nx + iy * ny + iz * nz), -ONE_Q14, ONE_Q14);
    c2 = clamp(round_q14(ox * nx + oy * ny + oz * nz), -ONE_Q14, ONE_Q14);
    cdd = clamp(round_q14(ix * ox + iy * oy + iz * oz), 0, ONE_Q14);
    cmin = c1 < c2 ? c1 : c2;
    cmax = c1 < c2 ? c2 : c1;
    sa = int_sqrt((64'd1 << 28) - longint'(cmin * cmin));
    sb = int_sqrt((64'd1 << 28) - longint'(cmax * cmax));
    p = b16 * longint'(cdd) * sa * sb;
    cm = cmax < 0 ? -cmax : cmax;
    if (cm == 0) cm = 1;
    dv = cm << 28;
    term = longint'((p + dv / 2) / dv);
    if (cmax < 0) term = -term;
    s = longint'(a16) + term;
    neg = s < 0;
    m = alb * longint'(neg ? -s : s);
    mh = m >> 24;
    ml = m & 64'hFFFFFF;
    lo = (ml * INV_PI_Q32 + (64'd1 << 46)) >> 24;
    mag = (mh * INV_PI_Q32 + lo) >> 23;
    if (neg) return mag > 8388608 ? OUT_MIN : refl_t'(-longint'(mag));
    return mag > 8388607 ? OUT_MAX : refl_t'(mag);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  assign pending = want_refl_q.size();

  initial fail_count = 0;

  // Predict on each accepted request, compare each accepted result.
  always @(posedge clk) begin
    refl_t want;
    if (!rst) begin
      if (req.valid && req.ready)
        want_refl_q.push_back(brdf_value(req.dir_in_x, req.dir_in_y, req.dir_in_z,
            req.dir_out_x, req.dir_out_y, req.dir_out_z, req.norm_x, req.norm_y,
            req.norm_z, req.rough, req.albedo_sample));
      if (rsp.valid && rsp.ready) begin
        if (want_refl_q.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = want_refl_q.pop_front();
          if (rsp.reflectance !== want)
            report_mismatch($sformatf("reflectance got %0d want %0d",
                rsp.reflectance, want));
        end
      end
    end
  end
endmodule

// File: test/tb_oren_nayar_brdf_eval.sv
// Testbench top: drives requests and result backpressure and gives the verdict.
module tb_oren_nayar_brdf_eval;
  timeunit 1ns;
  timeprecision 1ps;
  import onb_pkg::*;

  localparam int N_RANDOM = 800;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending, cycles;

  onb_req_if req ();
  onb_rsp_if rsp ();

  oren_nayar_brdf_eval u_top (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));
  onb_checker u_chk (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.sink),
                     .fail_count(fail_count), .pending(pending));

  initial forever #2 clk = ~clk;

  // Random vector component: mostly uniform between -16384 and 16384, sometimes exactly +-16384 or raw.
  function automatic q14_t rand_comp();
    case ($urandom_range(0, 9))
      0: return q14_t'($urandom);
      1: return q14_t'(16384);
      2: return q14_t'(-16384);
      default: return q14_t'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // Random near-unit vector built from two angles.
  task automatic rand_unit(output q14_t x, output q14_t y, output q14_t z);
    real th, ph;
    th = $urandom_range(0, 10000) * 3.14159265 / 10000.0;
    ph = $urandom_range(0, 10000) * 6.2831853 / 10000.0;
    x = q14_t'($rtoi(16384.0 * $sin(th) * $cos(ph)));
    y = q14_t'($rtoi(16384.0 * $sin(th) * $sin(ph)));
    z = q14_t'($rtoi(16384.0 * $cos(th)));
  endtask

  // Valid stays high into the next request when no gap is drawn.
  task automatic send(q14_t ix, q14_t iy, q14_t iz, q14_t ox, q14_t oy, q14_t oz,
                      q14_t nx, q14_t ny, q14_t nz, q15_t sg, q15_t al);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      req.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1;
    {req.dir_in_x, req.dir_in_y, req.dir_in_z} <= {ix, iy, iz};
    {req.dir_out_x, req.dir_out_y, req.dir_out_z} <= {ox, oy, oz};
    {req.norm_x, req.norm_y, req.norm_z} <= {nx, ny, nz};
    req.rough <= sg;
    req.albedo_sample <= al;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver stall per result.
  initial begin
    int w;
    rsp.ready = 0;
    forever begin
      @(negedge clk);
      w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      if (w != 0) begin
        rsp.ready <= 0;
        repeat (w) @(negedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    q14_t ix, iy, iz, ox, oy, oz, nx, ny, nz;
    req.valid = 0;
    {req.dir_in_x, req.dir_in_y, req.dir_in_z} = '0;
    {req.dir_out_x, req.dir_out_y, req.dir_out_z} = '0;
    {req.norm_x, req.norm_y, req.norm_z} = '0;
    req.rough = 0;
    req.albedo_sample = 0;
    repeat (2) @(negedge clk);
    rst <= 0;
    // Directed: normal incidence, grazing, right angle beta, both below, extremes.
    send(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 0, 16'd32768);
    send(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 16'd32768, 16'd32768);
    send(16384, 0, 0, 0, 0, 16384, 0, 0, 16384, 16'd16384, 16'd32768);
    send(16384, 0, 0, 16384, 0, 0, 0, 0, 16384, 16'd32768, 16'd32768);
    send(11585, 0, 11585, 11585, 0, 11585, 0, 0, 16384, 16'd32768, 16'd20000);
    send(0, 11585, -11585, 0, 11585, -11585, 0, 0, 16384, 16'd32768, 16'd32768);
    send(0, 0, -16384, 0, 0, -16384, 0, 0, 16384, 16'd30000, 16'd30000);
    send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
         16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF);
    send(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
         16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF);
    send(16'sh8000, 16'sh7FFF, 0, 16'sh7FFF, 16'sh8000, 1, 1, 16'sh8000, 16'sh7FFF,
         16'hFFFF, 16'hFFFF);
    send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(5, 0, 16384, 5, 0, 16384, 0, 0, 16384, 16'd1, 16'd1);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        ix = rand_comp(); iy = rand_comp(); iz = rand_comp();
        ox = rand_comp(); oy = rand_comp(); oz = rand_comp();
        nx = rand_comp(); ny = rand_comp(); nz = rand_comp();
      end else begin
        rand_unit(ix, iy, iz);
        rand_unit(ox, oy, oz);
        rand_unit(nx, ny, nz);
      end
      send(ix, iy, iz, ox, oy, oz, nx, ny, nz,
           $urandom_range(0, 7) == 0 ? q15_t'($urandom) : q15_t'($urandom_range(0, 32768)),
           $urandom_range(0, 7) == 0 ? q15_t'($urandom) : q15_t'($urandom_range(0, 32768)));
    end
    req.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
